>>> rtl/core/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg: shared definitions for the sort-then-search block
// Sizes, result codes, operation codes and the compare result type.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int unsigned MAX_ELEMENTS = 16;
  localparam int unsigned VALUE_WIDTH  = 16;

  // Fixed widths of the port fields.
  localparam int unsigned IN_W     = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 4;

  // Store index and element count widths.
  localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED  = 3'd0,
    ST_SORTED  = 3'd1,
    ST_FOUND   = 3'd2,
    ST_MISSING = 3'd3,
    ST_REJECT  = 3'd4
  } status_e;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  // Takes the low VALUE_WIDTH bits of the port value, sign-extended.
  function automatic val_t to_val(input logic signed [IN_W-1:0] v);
    return VALUE_WIDTH'(v);
  endfunction

endpackage

>>> rtl/core/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/stbs_cmp.sv
// ----------------------------------------------------------------------------
// stbs_cmp: shared signed comparator
// Orders the held operand against the word read from the store.
// ----------------------------------------------------------------------------
module stbs_cmp (
  input  stbs_pkg::val_t     a_i,
  input  stbs_pkg::val_t     b_i,
  output stbs_pkg::cmp_res_t res_o
);

  always_comb begin
    res_o.lt = (a_i < b_i);
    res_o.eq = (a_i == b_i);
  end

endmodule

>>> rtl/core/sort_then_binary_search_top.sv
// ----------------------------------------------------------------------------
// sort_then_binary_search_top: insertion sort with binary search
// Collects signed values, sorts them ascending when the set is sealed and
// answers search requests with a binary search over the sorted store.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i / in_stall_o op_i, value_i, last_i
//   out      source     out_valid_o/out_stall_i status_o, position_o
//
// A sealing load sorts the store with one shared comparator and one RAM
// read port, inserting each element after the first by shifting larger
// neighbors right. A search makes at most log2(N)+1 probes of the sorted
// store and ends in a hit or a miss.
// Reset clears the element count and the seal; the store itself holds no
// reset value, and only entries below the count are ever read.
// A stalled result sits in the output register while the next item is
// already taken in; that item finishes once the register is free.
module sort_then_binary_search_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic signed [stbs_pkg::IN_W-1:0]    value_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [stbs_pkg::STATUS_W-1:0]       status_o,
  output logic [stbs_pkg::POS_W-1:0]          position_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_RD,
    S_SORT_LD,
    S_SORT_CMP,
    S_SORT_PUT,
    S_SRCH_ISSUE,
    S_SRCH_CMP,
    S_EMIT
  } state_e;

  state_e                        state_q, state_d;
  logic [stbs_pkg::CNT_W-1:0]    count_q, count_d;
  logic                          sealed_q, sealed_d;
  logic [stbs_pkg::IDX_W-1:0]    i_q, i_d;
  logic [stbs_pkg::IDX_W-1:0]    p_q, p_d;
  logic [stbs_pkg::CNT_W-1:0]    lo_q, lo_d;
  logic [stbs_pkg::CNT_W-1:0]    hix_q, hix_d;
  logic [stbs_pkg::IDX_W-1:0]    mid_q, mid_d;
  stbs_pkg::val_t                opnd_q, opnd_d;
  stbs_pkg::status_e             res_status_q, res_status_d;
  logic [stbs_pkg::IDX_W-1:0]    res_pos_q, res_pos_d;
  logic                          out_valid_q, out_valid_d;
  stbs_pkg::status_e             out_status_q, out_status_d;
  logic [stbs_pkg::POS_W-1:0]    out_pos_q, out_pos_d;

  logic                          ram_we;
  logic [stbs_pkg::IDX_W-1:0]    ram_waddr;
  stbs_pkg::val_t                ram_wdata;
  logic [stbs_pkg::IDX_W-1:0]    ram_raddr;
  stbs_pkg::val_t                ram_rdata;
  stbs_pkg::cmp_res_t            cmp_res;

  logic                          in_xfer;
  logic [stbs_pkg::CNT_W-1:0]    cnt_eff;
  logic                          store_full;
  logic [stbs_pkg::CNT_W-1:0]    cnt_new;
  logic [stbs_pkg::CNT_W:0]      mid_sum;
  logic [stbs_pkg::IDX_W-1:0]    mid_idx;
  logic [stbs_pkg::CNT_W-1:0]    i_next;
  logic                          sort_more;

  stbs_ram #(
    .WIDTH (stbs_pkg::VALUE_WIDTH),
    .DEPTH (stbs_pkg::MAX_ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The single comparator: the held operand (key or element being
  // inserted) against the word just read from the store.
  stbs_cmp u_cmp (
    .a_i   (opnd_q),
    .b_i   (ram_rdata),
    .res_o (cmp_res)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign position_o  = out_pos_q;

  // A load into a sealed set starts a fresh set.
  assign cnt_eff    = sealed_q ? '0 : count_q;
  assign store_full = (cnt_eff >= stbs_pkg::CNT_W'(stbs_pkg::MAX_ELEMENTS));
  assign cnt_new    = store_full ? cnt_eff : cnt_eff + stbs_pkg::CNT_W'(1);

  // The upper bound is kept exclusive, so the midpoint floor((lo+hi)/2)
  // becomes (lo + hix - 1) / 2, which is never negative while lo < hix.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hix_q} - (stbs_pkg::CNT_W + 1)'(1);
  assign mid_idx = stbs_pkg::IDX_W'(mid_sum >> 1);

  assign i_next    = stbs_pkg::CNT_W'(i_q) + stbs_pkg::CNT_W'(1);
  assign sort_more = (i_next < count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    sealed_d     = sealed_q;
    i_d          = i_q;
    p_d          = p_q;
    lo_d         = lo_q;
    hix_d        = hix_q;
    mid_d        = mid_q;
    opnd_d       = opnd_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = opnd_q;
    ram_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_pos_d = '0;
          if (op_i == stbs_pkg::OP_LOAD) begin
            count_d  = cnt_new;
            sealed_d = last_i;
            if (store_full) begin
              res_status_d = stbs_pkg::ST_REJECT;
            end else begin
              ram_we       = 1'b1;
              ram_waddr    = stbs_pkg::IDX_W'(cnt_eff);
              ram_wdata    = stbs_pkg::to_val(value_i);
              res_status_d = last_i ? stbs_pkg::ST_SORTED : stbs_pkg::ST_LOADED;
            end
            if (last_i && (cnt_new > stbs_pkg::CNT_W'(1))) begin
              i_d     = stbs_pkg::IDX_W'(1);
              state_d = S_SORT_RD;
            end else begin
              state_d = S_EMIT;
            end
          end else if (!sealed_q) begin
            res_status_d = stbs_pkg::ST_REJECT;
            state_d      = S_EMIT;
          end else begin
            opnd_d  = stbs_pkg::to_val(value_i);
            lo_d    = '0;
            hix_d   = count_q;
            state_d = S_SRCH_ISSUE;
          end
        end
      end

      S_SORT_RD: begin
        ram_raddr = i_q;
        p_d       = i_q;
        state_d   = S_SORT_LD;
      end

      S_SORT_LD: begin
        // Element to insert arrives; fetch its left neighbor.
        opnd_d    = ram_rdata;
        ram_raddr = p_q - stbs_pkg::IDX_W'(1);
        state_d   = S_SORT_CMP;
      end

      S_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        if (cmp_res.lt) begin
          // Neighbor is larger: shift it right and keep walking left.
          ram_wdata = ram_rdata;
          p_d       = p_q - stbs_pkg::IDX_W'(1);
          if (p_q == stbs_pkg::IDX_W'(1)) begin
            state_d = S_SORT_PUT;
          end else begin
            ram_raddr = p_q - stbs_pkg::IDX_W'(2);
          end
        end else begin
          ram_wdata = opnd_q;
          if (sort_more) begin
            i_d     = stbs_pkg::IDX_W'(i_next);
            state_d = S_SORT_RD;
          end else begin
            state_d = S_EMIT;
          end
        end
      end

      S_SORT_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        ram_wdata = opnd_q;
        if (sort_more) begin
          i_d     = stbs_pkg::IDX_W'(i_next);
          state_d = S_SORT_RD;
        end else begin
          state_d = S_EMIT;
        end
      end

      S_SRCH_ISSUE: begin
        if (lo_q < hix_q) begin
          ram_raddr = mid_idx;
          mid_d     = mid_idx;
          state_d   = S_SRCH_CMP;
        end else begin
          res_status_d = stbs_pkg::ST_MISSING;
          state_d      = S_EMIT;
        end
      end

      S_SRCH_CMP: begin
        if (cmp_res.eq) begin
          res_status_d = stbs_pkg::ST_FOUND;
          res_pos_d    = mid_q;
          state_d      = S_EMIT;
        end else if (cmp_res.lt) begin
          hix_d   = stbs_pkg::CNT_W'(mid_q);
          state_d = S_SRCH_ISSUE;
        end else begin
          lo_d    = stbs_pkg::CNT_W'(mid_q) + stbs_pkg::CNT_W'(1);
          state_d = S_SRCH_ISSUE;
        end
      end

      S_EMIT: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = stbs_pkg::POS_W'(res_pos_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      sealed_q     <= 1'b0;
      i_q          <= '0;
      p_q          <= '0;
      lo_q         <= '0;
      hix_q        <= '0;
      mid_q        <= '0;
      opnd_q       <= '0;
      res_status_q <= stbs_pkg::ST_LOADED;
      res_pos_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= stbs_pkg::ST_LOADED;
      out_pos_q    <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      sealed_q     <= sealed_d;
      i_q          <= i_d;
      p_q          <= p_d;
      lo_q         <= lo_d;
      hix_q        <= hix_d;
      mid_q        <= mid_d;
      opnd_q       <= opnd_d;
      res_status_q <= res_status_d;
      res_pos_q    <= res_pos_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_pos_q    <= out_pos_d;
    end
  end

endmodule
